// ----- hdl/ksv_pkg.sv -----
package ksv_pkg;

   localparam int DELAY_W = 10;
   localparam int DRUM_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 10;
   localparam int LFSR_W = 16;
   localparam int RAND_W = 7;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd100;
   localparam logic [DRUM_W-1:0] DRUM_RESET = 8'd128;

   // Reciprocal scaling used to reduce the delay length modulo the ring depth.
   localparam int RECIP_SHIFT = 20;
   localparam int PROD_W = 27;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE       = 2'd0,
      CSR_DELAY_LENGTH = 2'd1,
      CSR_DRUMNESS     = 2'd2
   } ksv_csr_type;

   typedef struct packed {
      logic              enable;
      logic [DRUM_W-1:0] drumness;
      logic              settle;
   } ksv_cfg_type;

   typedef struct packed {
      logic exc;
      logic negate;
      logic hist_valid;
   } ksv_tick_type;

   typedef struct packed {
      logic a_valid;
      logic move;
      logic fwd;
   } ksv_status_type;

endpackage

// ----- hdl/ksv_ram.sv -----
module ksv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ksv_cfg.sv -----
module ksv_cfg import ksv_pkg::*; #(
   parameter int RING_DEPTH = 1024,
   localparam int AW = $clog2(RING_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output ksv_cfg_type           cfg,
   output logic [AW-1:0]         dmod
);

   localparam int RECIP = (1 << RECIP_SHIFT) / RING_DEPTH;
   localparam logic [AW-1:0] DMOD_RESET = AW'(int'(DELAY_RESET) % RING_DEPTH);
   localparam logic [DELAY_W-1:0] QUOT_RESET = DELAY_W'(int'(DELAY_RESET) / RING_DEPTH);

   logic              enable_ff, enable_in;
   logic [DRUM_W-1:0] drum_ff, drum_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [DELAY_W-1:0] quot_ff, quot_in;
   logic [AW-1:0]     dmod_ff, dmod_in;
   logic              settle_ff, settle_in;

   logic [PROD_W-1:0] prod;
   logic [31:0]       rem_wide;
   logic [31:0]       rem_fix;

   always_comb begin
      enable_in = enable_ff;
      drum_in   = drum_ff;
      delay_in  = delay_ff;
      quot_in   = quot_ff;
      settle_in = 1'b0;
      // Quotient estimate is low by at most one; the remainder stage corrects it.
      prod = PROD_W'(csr_wdata[DELAY_W-1:0]) * PROD_W'(RECIP);
      if (csr_write_en) begin
         case (ksv_csr_type'(csr_index))
            CSR_ENABLE: begin
               enable_in = csr_wdata[0];
            end
            CSR_DELAY_LENGTH: begin
               delay_in  = csr_wdata[DELAY_W-1:0];
               quot_in   = DELAY_W'(prod >> RECIP_SHIFT);
               settle_in = 1'b1;
            end
            CSR_DRUMNESS: begin
               drum_in = csr_wdata[DRUM_W-1:0];
            end
            default: begin
            end
         endcase
      end
      rem_wide = 32'(delay_ff) - 32'(quot_ff) * 32'(RING_DEPTH);
      rem_fix  = (rem_wide >= 32'(RING_DEPTH)) ? rem_wide - 32'(RING_DEPTH) : rem_wide;
      dmod_in  = rem_fix[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         drum_ff   <= DRUM_RESET;
         delay_ff  <= DELAY_RESET;
         quot_ff   <= QUOT_RESET;
         dmod_ff   <= DMOD_RESET;
         settle_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         drum_ff   <= drum_in;
         delay_ff  <= delay_in;
         quot_ff   <= quot_in;
         dmod_ff   <= dmod_in;
         settle_ff <= settle_in;
      end
   end

   assign cfg.enable   = enable_ff;
   assign cfg.drumness = drum_ff;
   assign cfg.settle   = settle_ff;
   assign dmod         = dmod_ff;

endmodule

// ----- hdl/ksv_ctrl.sv -----
module ksv_ctrl import ksv_pkg::*; #(
   parameter int RING_DEPTH = 1024,
   localparam int AW = $clog2(RING_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic          trigger,
   input  ksv_cfg_type   cfg,
   input  logic [AW-1:0] dmod,
   output ksv_tick_type  tick,
   output logic [AW-1:0] tick_cursor,
   output logic [AW-1:0] hist_addr
);

   localparam logic [AW:0] DEPTH_X = (AW+1)'(RING_DEPTH);
   localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

   logic [AW-1:0]     cursor_ff, cursor_in;
   logic              wrapped_ff, wrapped_in;
   logic [AW-1:0]     end_ff, end_in;
   logic              exciting_ff, exciting_in;
   logic [LFSR_W-1:0] lfsr_ff, lfsr_in;

   logic              exc_now;
   logic [AW:0]       end_sum;
   logic [AW-1:0]     end_trig;
   logic [AW-1:0]     end_now;
   logic [AW-1:0]     cursor_next;
   logic [LFSR_W-1:0] lfsr_step;
   logic [AW:0]       back_sum;

   always_comb begin
      exc_now  = trigger | exciting_ff;
      end_sum  = {1'b0, cursor_ff} + {1'b0, dmod};
      end_trig = (end_sum >= DEPTH_X) ? AW'(end_sum - DEPTH_X) : end_sum[AW-1:0];
      end_now  = trigger ? end_trig : end_ff;
      cursor_next = (cursor_ff == LAST) ? '0 : cursor_ff + AW'(1);

      lfsr_step = {1'b0, lfsr_ff[LFSR_W-1:1]} ^ (lfsr_ff[0] ? LFSR_MASK : '0);

      back_sum  = (cursor_ff >= dmod) ? {1'b0, cursor_ff} - {1'b0, dmod}
                                      : {1'b0, cursor_ff} + DEPTH_X - {1'b0, dmod};
      hist_addr = back_sum[AW-1:0];

      // The ring is filled in cursor order, so an entry holds data once the
      // cursor has passed it or the cursor has gone round at least once.
      tick.exc        = exc_now;
      tick.negate     = {1'b0, lfsr_step[RAND_W-1:0]} >= cfg.drumness;
      tick.hist_valid = wrapped_ff | (hist_addr < cursor_ff);
      tick_cursor     = cursor_ff;

      cursor_in   = cursor_ff;
      wrapped_in  = wrapped_ff;
      end_in      = end_ff;
      exciting_in = exciting_ff;
      lfsr_in     = lfsr_ff;
      if (load) begin
         cursor_in   = cursor_next;
         wrapped_in  = wrapped_ff | (cursor_ff == LAST);
         end_in      = end_now;
         exciting_in = exc_now & (cursor_next != end_now);
         if (!exc_now) begin
            lfsr_in = lfsr_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= '0;
         wrapped_ff  <= 1'b0;
         end_ff      <= '0;
         exciting_ff <= 1'b0;
         lfsr_ff     <= LFSR_SEED;
      end else begin
         cursor_ff   <= cursor_in;
         wrapped_ff  <= wrapped_in;
         end_ff      <= end_in;
         exciting_ff <= exciting_in;
         lfsr_ff     <= lfsr_in;
      end
   end

endmodule

// ----- hdl/ksv_dp.sv -----
module ksv_dp import ksv_pkg::*; #(
   parameter int RING_DEPTH = 1024,
   parameter int SAMPLE_BITS = 16,
   localparam int AW = $clog2(RING_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  ksv_tick_type                  tick,
   input  logic [AW-1:0]                 tick_cursor,
   input  logic [AW-1:0]                 hist_addr,
   input  logic signed [SAMPLE_BITS-1:0] excitation,
   input  logic [SAMPLE_BITS-1:0]        ram_rd_data,
   output logic                          ram_wr_en,
   output logic [AW-1:0]                 ram_wr_addr,
   output logic [SAMPLE_BITS-1:0]        ram_wr_data,
   output ksv_status_type                status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample
);

   localparam int SB = SAMPLE_BITS;
   localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
   localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};

   logic                 a_valid_ff, a_valid_in;
   ksv_tick_type         a_tick_ff;
   logic                 a_fwd_ff;
   logic [AW-1:0]        a_cursor_ff;
   logic signed [SB-1:0] a_exc_ff;
   logic signed [SB-1:0] fwd_data_ff;
   logic signed [SB-1:0] prev_ff, prev_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0] rsp_sample_ff;

   logic                 move;
   logic signed [SB-1:0] hist;
   logic signed [SB:0]   sum;
   logic signed [SB:0]   adj;
   logic signed [SB-1:0] avg;
   logic signed [SB-1:0] neg_avg;
   logic signed [SB-1:0] result;

   always_comb begin
      move = a_valid_ff & (~rsp_valid_ff | rsp_ready);

      if (!a_tick_ff.hist_valid) begin
         hist = '0;
      end else if (a_fwd_ff) begin
         hist = fwd_data_ff;
      end else begin
         hist = $signed(ram_rd_data);
      end

      // Add one to a negative sum before the shift so the halving rounds
      // toward zero.
      sum     = {prev_ff[SB-1], prev_ff} + {hist[SB-1], hist};
      adj     = sum + (SB+1)'(sum[SB]);
      avg     = adj[SB:1];
      neg_avg = (avg == SMIN) ? SMAX : -avg;

      if (a_tick_ff.exc) begin
         result = a_exc_ff;
      end else if (a_tick_ff.negate) begin
         result = neg_avg;
      end else begin
         result = avg;
      end

      a_valid_in = load | (a_valid_ff & ~move);
      prev_in    = move ? result : prev_ff;

      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         a_tick_ff    <= '0;
         a_fwd_ff     <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         if (load) begin
            a_tick_ff <= tick;
            // The older transaction may write the very entry read this cycle.
            a_fwd_ff  <= move & (a_cursor_ff == hist_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_cursor_ff <= tick_cursor;
         a_exc_ff    <= excitation;
         fwd_data_ff <= result;
      end
      if (move) begin
         rsp_sample_ff <= result;
      end
   end

   assign ram_wr_en      = move;
   assign ram_wr_addr    = a_cursor_ff;
   assign ram_wr_data    = result;
   assign status.a_valid = a_valid_ff;
   assign status.move    = move;
   assign status.fwd     = a_fwd_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = rsp_sample_ff;

endmodule

// ----- hdl/karplus_strong_voice_unit.sv -----
// Each sample passes a working register, then the output register that drives rsp_valid.
// Throughput: one transaction per cycle while rsp_ready is high; the single ring RAM read
// is issued at acceptance and the write of the previous result is forwarded when both hit
// the same entry. A write of delay_length holds req_ready low for one cycle while the
// length is reduced. Reset (synchronous, active high) clears control and configuration
// registers; the ring is not swept, entries the cursor has not yet passed read as zero.
module karplus_strong_voice_unit import ksv_pkg::*; #(
   parameter int RING_DEPTH = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_trigger,
   input  logic signed [SAMPLE_BITS-1:0] req_excitation_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample
);

   localparam int AW = $clog2(RING_DEPTH);

   ksv_cfg_type            cfg;
   logic [AW-1:0]          dmod;
   ksv_tick_type           tick;
   logic [AW-1:0]          tick_cursor;
   logic [AW-1:0]          hist_addr;
   ksv_status_type         dp_status;
   logic                   load;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [SAMPLE_BITS-1:0] ram_wr_data;
   logic [SAMPLE_BITS-1:0] ram_rd_data;

   assign req_ready = (~dp_status.a_valid | dp_status.move) & ~cfg.settle;
   // A transaction taken while the voice is disabled is dropped.
   assign load = req_valid & req_ready & cfg.enable;

   ksv_cfg #(
      .RING_DEPTH (RING_DEPTH)
   ) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg),
      .dmod         (dmod)
   );

   ksv_ctrl #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .trigger     (req_trigger),
      .cfg         (cfg),
      .dmod        (dmod),
      .tick        (tick),
      .tick_cursor (tick_cursor),
      .hist_addr   (hist_addr)
   );

   ksv_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (load),
      .rd_addr (hist_addr),
      .rd_data (ram_rd_data)
   );

   ksv_dp #(
      .RING_DEPTH  (RING_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .tick        (tick),
      .tick_cursor (tick_cursor),
      .hist_addr   (hist_addr),
      .excitation  (req_excitation_sample),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .status      (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_sample  (rsp_sample)
   );

   // A read that collides with the same-cycle ring write must be forwarded.
   a_fwd_on_collision: assert property (@(posedge clock) disable iff (reset)
      (load && ram_wr_en && ram_wr_addr == hist_addr) |=> dp_status.fwd)
      else $error("ring read colliding with a write was not forwarded");

   // The ring is written only when a result moves into a free output register.
   a_no_write_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !ram_wr_en)
      else $error("ring written while the output register is stalled");

   // A new transaction is only taken when the working register is free or draining.
   a_ready_has_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!dp_status.a_valid || dp_status.move))
      else $error("input accepted with no room in the working register");

endmodule
